// ===== src/nfc_response_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
// No dependencies; included by the top level only.
`ifndef NFC_RESPONSE_DEFRAMER_DEFINES_SVH
`define NFC_RESPONSE_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define NFCD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define NFCD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/nfcd_pkg.sv =====
// Types and constants for the NFC response deframer.
// No dependencies; used by the interfaces and the top level.
package nfcd_pkg;

  // Parse phase, one-hot
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_HEADER = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_DCS    = 5'b01000,
    PH_POST   = 5'b10000
  } phase_e;

  // Result kind codes
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef logic [7:0] byte_t;

  localparam byte_t PREAMBLE_BYTE   = 8'h00;
  localparam byte_t START_CODE_1    = 8'h00;
  localparam byte_t START_CODE_2    = 8'hFF;
  localparam byte_t TFI_HOST_BYTE   = 8'hD5;
  localparam byte_t MAX_PAYLOAD_RST = 8'd32;

  // Header byte positions
  localparam byte_t POS_PREAMBLE = 8'd0;
  localparam byte_t POS_START_1  = 8'd1;
  localparam byte_t POS_START_2  = 8'd2;
  localparam byte_t POS_LEN      = 8'd3;
  localparam byte_t POS_TFI      = 8'd5;

endpackage

// ===== src/nfcd_in_if.sv =====
// Byte input channel of the NFC response deframer.
// Depends on nfcd_pkg.
interface nfcd_in_if;
  import nfcd_pkg::*;

  logic  valid;
  logic  ready;
  logic  frame_start;
  byte_t rx_byte;

  modport source (output valid, frame_start, rx_byte, input ready);
  modport sink   (input valid, frame_start, rx_byte, output ready);
endinterface

// ===== src/nfcd_out_if.sv =====
// Result channel of the NFC response deframer.
// Depends on nfcd_pkg.
interface nfcd_out_if;
  import nfcd_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  byte_t       payload_byte;
  byte_t       payload_count;

  modport source (output valid, result_kind, payload_byte, payload_count, input ready);
  modport sink   (input valid, result_kind, payload_byte, payload_count, output ready);
endinterface

// ===== src/nfc_response_deframer.sv =====
// NFC response deframer: parses controller-to-host information frames.
// Depends on nfcd_pkg, nfcd_in_if, nfcd_out_if and the assertion macro header.
//
// Usage:
//   in_i carries one received byte per transfer; frame_start marks the first
//   byte of a read. out_o delivers at most one result per input byte: a data
//   byte (kind 0), frame complete with kept count (kind 1) or header error
//   (kind 2). cfg_we_i/cfg_data_i write max_payload, sampled at the TFI byte.
//   Throughput: one byte per cycle. The parse step is a single combinational
//   pass from the state registers and the input byte into the result register.
//   Latency: a result is valid the cycle after its byte is transferred.
//   When the receiver stalls, the result register holds and in_i.ready drops
//   until the result is taken; ready is high whenever the result register is
//   empty or being emptied in the same cycle.
//   Reset clears the parse state to idle, drops any pending result and sets
//   max_payload to 32. Bytes before the first frame_start are ignored.
`include "nfc_response_deframer_defines.svh"

module nfc_response_deframer (
  input  logic            clk_i,
  input  logic            rst_ni,
  nfcd_in_if.sink         in_i,
  nfcd_out_if.source      out_o,
  input  logic            cfg_we_i,
  input  nfcd_pkg::byte_t cfg_data_i
);
  import nfcd_pkg::*;

  // Parse state
  phase_e phase_q, phase_d;
  byte_t  pos_q, pos_d;
  byte_t  len_q, len_d;
  logic   bad_q, bad_d;
  byte_t  kept_q, kept_d;
  byte_t  max_payload_q;

  // Start-adjusted view of the state
  phase_e phase_eff;
  byte_t  pos_eff, len_eff, kept_eff, total;
  logic   bad_eff;

  // Result of the current byte
  logic   res_valid;
  kind_e  res_kind;
  byte_t  res_byte, res_count;

  // Result register
  logic   out_valid_q;
  kind_e  out_kind_q;
  byte_t  out_byte_q, out_count_q;

  logic   in_fire;
  byte_t  b;

  assign b        = in_i.rx_byte;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_fire  = in_i.valid && in_i.ready;

  // A start byte restarts the header
  always_comb begin
    if (in_i.frame_start) begin
      phase_eff = PH_HEADER;
      pos_eff   = '0;
      len_eff   = '0;
      bad_eff   = 1'b0;
      kept_eff  = '0;
    end else begin
      phase_eff = phase_q;
      pos_eff   = pos_q;
      len_eff   = len_q;
      bad_eff   = bad_q;
      kept_eff  = kept_q;
    end
  end

  // Data length: LEN-1, or 0 for LEN 0
  assign total = (len_eff != 8'd0) ? len_eff - 8'd1 : 8'd0;

  // Parse step
  always_comb begin
    phase_d   = phase_eff;
    pos_d     = pos_eff;
    len_d     = len_eff;
    bad_d     = bad_eff;
    kept_d    = kept_eff;
    res_valid = 1'b0;
    res_kind  = KIND_DATA;
    res_byte  = '0;
    res_count = '0;
    unique case (phase_eff)
      PH_HEADER: begin
        if ((pos_eff == POS_PREAMBLE && b != PREAMBLE_BYTE) ||
            (pos_eff == POS_START_1 && b != START_CODE_1) ||
            (pos_eff == POS_START_2 && b != START_CODE_2)) begin
          bad_d = 1'b1;
        end
        if (pos_eff == POS_LEN) begin
          len_d = b;
        end
        if (pos_eff < POS_TFI) begin
          pos_d = pos_eff + 8'd1;
        end else if (bad_eff || b != TFI_HOST_BYTE) begin
          bad_d     = 1'b1;
          phase_d   = PH_IDLE;
          pos_d     = '0;
          res_valid = 1'b1;
          res_kind  = KIND_ERR;
        end else begin
          kept_d  = (total > max_payload_q) ? max_payload_q : total;
          pos_d   = '0;
          phase_d = (total == 8'd0) ? PH_DCS : PH_DATA;
        end
      end
      PH_DATA: begin
        if (pos_eff < kept_eff) begin
          res_valid = 1'b1;
          res_kind  = KIND_DATA;
          res_byte  = b;
        end
        pos_d = pos_eff + 8'd1;
        if (({1'b0, pos_eff} + 9'd1) >= {1'b0, total}) begin
          phase_d = PH_DCS;
        end
      end
      PH_DCS: begin
        phase_d = PH_POST;
      end
      PH_POST: begin
        phase_d   = PH_IDLE;
        pos_d     = '0;
        res_valid = 1'b1;
        res_kind  = KIND_DONE;
        res_count = kept_eff;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      pos_q         <= '0;
      len_q         <= '0;
      bad_q         <= 1'b0;
      kept_q        <= '0;
      max_payload_q <= MAX_PAYLOAD_RST;
    end else begin
      if (cfg_we_i) begin
        max_payload_q <= cfg_data_i;
      end
      if (in_fire) begin
        phase_q <= phase_d;
        pos_q   <= pos_d;
        len_q   <= len_d;
        bad_q   <= bad_d;
        kept_q  <= kept_d;
      end
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_kind_q  <= res_kind;
      out_byte_q  <= res_byte;
      out_count_q <= res_count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.result_kind   = out_kind_q;
  assign out_o.payload_byte  = out_byte_q;
  assign out_o.payload_count = out_count_q;

  // Checks
  `NFCD_ASSERT_NOW(a_stall_blocks_input, clk_i, rst_ni,
    out_valid_q && !out_o.ready, !in_i.ready, "byte taken while result stalled")
  `NFCD_ASSERT_NEXT(a_result_registered, clk_i, rst_ni,
    in_fire && res_valid, out_valid_q, "result of a byte was lost")
  `NFCD_ASSERT_NEXT(a_frame_end_idle, clk_i, rst_ni,
    in_fire && res_valid && res_kind != KIND_DATA, phase_q == PH_IDLE,
    "parser not idle after frame end")

endmodule
